// File: hdl/fsr_pkg.sv
// shared constants and types for the first substring remover
package fsr_pkg;

  localparam int CHAR_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 64;

  // register index, taken from paddr[3] (8-byte register spacing)
  typedef enum logic {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              out_valid;
    logic              out_last;
  } result_t;

endpackage

// File: hdl/fsr_if.sv
// valid/ready channels for the character stream and the result stream
interface fsr_char_if;
  logic                      valid;
  logic                      ready;
  logic [fsr_pkg::CHAR_W-1:0] char_value;
  logic                      is_last;

  modport source (output valid, output char_value, output is_last, input ready);
  modport sink (input valid, input char_value, input is_last, output ready);
endinterface

interface fsr_result_if;
  logic                      valid;
  logic                      ready;
  logic [fsr_pkg::CHAR_W-1:0] out_char;
  logic                      out_valid;
  logic                      out_last;

  modport source (output valid, output out_char, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_char, input out_valid, input out_last,
                output ready);
endinterface

// File: hdl/first_substring_remover.sv
// top level: window cell chain, emit control and output register
//
//  channel  | role   | payload                          | accepted when
//  ---------+--------+----------------------------------+-------------------------
//  chars    | sink   | char_value[7:0], is_last         | chars.valid & chars.ready
//  result   | source | out_char[7:0], out_valid, out_last | result.valid & result.ready
//  apb      | slave  | 64-bit registers at 0x0 and 0x8  | psel & penable & pwrite
//
// one character per cycle while each character releases at most one result.
// a character that releases more than one result (end-of-string flush or a shortened
// pattern length) holds off input until the rest are out: the emit path reads one
// window cell per cycle while the output slot is free. a result sits in the output
// register, and input keeps flowing when that register is taken in the same cycle.
// synchronous reset empties the window and the output register; no clearing pass.
module first_substring_remover #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fsr_pkg::ADDR_W-1:0] paddr,
  input  logic [fsr_pkg::DATA_W-1:0] pwdata,
  output logic [fsr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  fsr_char_if.sink                   chars,
  fsr_result_if.source               result
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [FW-1:0]              len_used;
  logic [fsr_pkg::CHAR_W-1:0] cell_pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     cell_use;
  logic [fsr_pkg::CHAR_W-1:0] hold [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     hit;

  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] pend, pend_next;
  logic          match_done, match_done_next;
  logic          tail_clr, tail_clr_next;
  logic          tail_last, tail_last_next;

  logic [FW-1:0]              fill_inc;
  logic [FW-1:0]              emit_cnt;
  logic                       clr;
  logic                       active;
  logic                       match;
  logic                       accept;
  logic                       slot_free;
  logic                       drain;
  logic                       load;
  logic [fsr_pkg::CHAR_W-1:0] emit_char;
  fsr_pkg::result_t           item;
  fsr_pkg::result_t           oreg;
  logic                       oreg_valid;

  fsr_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .len_used (len_used),
    .cell_pat (cell_pat),
    .cell_use (cell_use)
  );

  // newest character enters cell 0
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_head
      fsr_cell u_cell (
        .clk    (clk),
        .shift  (accept),
        .din    (chars.char_value),
        .pat    (cell_pat[j]),
        .in_use (cell_use[j]),
        .q      (hold[j]),
        .hit    (hit[j])
      );
    end else begin : g_body
      fsr_cell u_cell (
        .clk    (clk),
        .shift  (accept),
        .din    (hold[j-1]),
        .pat    (cell_pat[j]),
        .in_use (cell_use[j]),
        .q      (hold[j]),
        .hit    (hit[j])
      );
    end
  end

  assign slot_free   = !oreg_valid || result.ready;
  assign chars.ready = (pend == '0) && slot_free;
  assign accept      = chars.valid && chars.ready;
  assign drain       = (pend != '0) && slot_free;

  assign fill_inc = fill + FW'(1);
  assign active   = !match_done && (len_used != '0);
  assign match    = (&hit) && (fill_inc >= len_used);

  // how many of the oldest characters leave the window on this transfer
  always_comb begin
    emit_cnt = fill_inc;
    clr      = 1'b0;
    if (active) begin
      if (fill_inc < len_used) begin
        emit_cnt = '0;
      end else if (match) begin
        emit_cnt = fill_inc - len_used;
        clr      = 1'b1;
      end else begin
        emit_cnt = fill_inc - len_used + FW'(1);
      end
    end
    if (chars.is_last && !clr) begin
      emit_cnt = fill_inc;
    end
  end

  // oldest live character: before the shift it sits at fill-1, or is the new one
  always_comb begin
    emit_char = chars.char_value;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (fill == FW'(j + 1)) emit_char = hold[j];
    end
  end

  always_comb begin
    fill_next       = fill;
    pend_next       = pend;
    match_done_next = match_done;
    tail_clr_next   = tail_clr;
    tail_last_next  = tail_last;
    load            = 1'b0;
    item            = '{out_char: emit_char, out_valid: 1'b1, out_last: 1'b0};
    if (accept) begin
      match_done_next = chars.is_last ? 1'b0 : (match_done || (active && match));
      tail_clr_next   = clr || chars.is_last;
      tail_last_next  = chars.is_last;
      if (emit_cnt != '0) begin
        load          = 1'b1;
        item.out_last = chars.is_last && (emit_cnt == FW'(1));
        pend_next     = emit_cnt - FW'(1);
        if ((emit_cnt == FW'(1)) && (clr || chars.is_last)) fill_next = '0;
        else                                                fill_next = fill;
      end else begin
        pend_next = '0;
        fill_next = (clr || chars.is_last) ? '0 : fill_inc;
        if (chars.is_last) begin
          load = 1'b1;
          item = '{out_char: '0, out_valid: 1'b0, out_last: 1'b1};
        end
      end
    end else if (drain) begin
      load          = 1'b1;
      item.out_last = (pend == FW'(1)) && tail_last;
      pend_next     = pend - FW'(1);
      fill_next     = ((pend == FW'(1)) && tail_clr) ? '0 : fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      pend       <= '0;
      match_done <= 1'b0;
      tail_clr   <= 1'b0;
      tail_last  <= 1'b0;
      oreg_valid <= 1'b0;
    end else begin
      fill       <= fill_next;
      pend       <= pend_next;
      match_done <= match_done_next;
      tail_clr   <= tail_clr_next;
      tail_last  <= tail_last_next;
      if (load)              oreg_valid <= 1'b1;
      else if (result.ready) oreg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oreg <= item;
    end
  end

  assign result.valid     = oreg_valid;
  assign result.out_char  = oreg.out_char;
  assign result.out_valid = oreg.out_valid;
  assign result.out_last  = oreg.out_last;

endmodule

// File: hdl/fsr_cfg.sv
// configuration registers and per-cell pattern alignment
module fsr_cfg #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [fsr_pkg::DATA_W-1:0]   pwdata,
  output logic [fsr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [$clog2(MAX_PATTERN+1)-1:0] len_used,
  output logic [fsr_pkg::CHAR_W-1:0]   cell_pat [MAX_PATTERN],
  output logic [MAX_PATTERN-1:0]       cell_use
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [fsr_pkg::PATTERN_W-1:0] pattern_bytes;
  logic [fsr_pkg::LEN_W-1:0]     pattern_length;
  logic                          wr;
  fsr_pkg::reg_index_t           idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = fsr_pkg::reg_index_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (wr) begin
      unique case (idx)
        fsr_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= pwdata[fsr_pkg::PATTERN_W-1:0];
        fsr_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[fsr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fsr_pkg::REG_PATTERN_BYTES:  prdata = pattern_bytes;
      fsr_pkg::REG_PATTERN_LENGTH: prdata = {{(fsr_pkg::DATA_W-fsr_pkg::LEN_W){1'b0}},
                                             pattern_length};
      default:                     prdata = '0;
    endcase
  end

  // lengths beyond the cell count saturate
  always_comb begin
    if (int'(pattern_length) > MAX_PATTERN) len_used = FW'(MAX_PATTERN);
    else                                    len_used = FW'(pattern_length);
  end

  // cell j holds the j-th newest character, so it meets pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      cell_use[j] = (j < int'(len_used));
      cell_pat[j] = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (int'(len_used) == j + k + 1) begin
          cell_pat[j] = pattern_bytes[fsr_pkg::CHAR_W*k +: fsr_pkg::CHAR_W];
        end
      end
    end
  end

endmodule

// File: hdl/fsr_cell.sv
// one window cell: holds a character, shifts it on, compares the incoming one
module fsr_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [fsr_pkg::CHAR_W-1:0] din,
  input  logic [fsr_pkg::CHAR_W-1:0] pat,
  input  logic                       in_use,
  output logic [fsr_pkg::CHAR_W-1:0] q,
  output logic                       hit
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  // compare is taken on the value that enters with this transfer
  assign hit = !in_use || (din == pat);

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// testbench for first_substring_remover: directed and random strings checked against a pattern-strip model
module tb;

  localparam int MAXP           = 8;
  localparam int SETTLE         = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 120;

  typedef logic [fsr_pkg::CHAR_W-1:0] char_t;
  typedef logic [fsr_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    logic [fsr_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } char_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [fsr_pkg::ADDR_W-1:0] paddr = '0;
  logic [fsr_pkg::DATA_W-1:0] pwdata = '0;
  logic [fsr_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  fsr_char_if   chars_bus ();
  fsr_result_if result_bus ();

  first_substring_remover DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chars   (chars_bus),
    .result  (result_bus)
  );

  always #10 clk = ~clk;

  // mirror of the registers and the window
  logic [fsr_pkg::PATTERN_W-1:0] pat_bytes;
  logic [fsr_pkg::LEN_W-1:0]     pat_len;
  logic [fsr_pkg::CHAR_W-1:0]    win [MAXP];
  int unsigned                   win_fill;
  bit                            match_seen;

  char_item_t       char_q[$];
  fsr_pkg::result_t stripped_q[$];

  bit          quiet;
  int          in_gap;
  int          out_gap;
  int unsigned errors;
  int unsigned idle_cycles;

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void release_oldest();
    fsr_pkg::result_t r;
    r.out_char  = win[0];
    r.out_valid = 1'b1;
    r.out_last  = 1'b0;
    for (int i = 1; i < win_fill && i < MAXP; i++) win[i-1] = win[i];
    win_fill--;
    stripped_q.push_back(r);
  endfunction

  // expected output of one accepted character
  function automatic void strip_char(char_item_t it);
    int unsigned      len;
    int               base;
    bit               hit;
    fsr_pkg::result_t r;
    len  = (pat_len > MAXP) ? MAXP : pat_len;
    base = stripped_q.size();
    if (win_fill >= MAXP) release_oldest();
    win[win_fill] = it.ch;
    win_fill++;
    if (!match_seen && len > 0) begin
      while (win_fill > len) release_oldest();
      if (win_fill == len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++)
          if (win[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
        if (hit) begin
          win_fill   = 0;
          match_seen = 1'b1;
        end else begin
          release_oldest();
        end
      end
    end else begin
      while (win_fill > 0) release_oldest();
    end
    if (it.last) begin
      while (win_fill > 0) release_oldest();
      // everything removed: end-only marker
      if (stripped_q.size() == base) begin
        r = '0;
        stripped_q.push_back(r);
      end
      r = stripped_q.pop_back();
      r.out_last = 1'b1;
      stripped_q.push_back(r);
      win_fill   = 0;
      match_seen = 1'b0;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      chars_bus.valid      <= 1'b0;
      chars_bus.char_value <= '0;
      chars_bus.is_last    <= 1'b0;
      in_gap = 0;
    end else begin
      if (chars_bus.valid && chars_bus.ready)
        strip_char('{ch: chars_bus.char_value, last: chars_bus.is_last});
      if (!chars_bus.valid || chars_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          chars_bus.valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          char_item_t nxt;
          nxt = char_q.pop_front();
          chars_bus.valid      <= 1'b1;
          chars_bus.char_value <= nxt.ch;
          chars_bus.is_last    <= nxt.last;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
        end else begin
          chars_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        fsr_pkg::result_t got;
        fsr_pkg::result_t want;
        got = '{out_char: result_bus.out_char, out_valid: result_bus.out_valid,
                out_last: result_bus.out_last};
        if (stripped_q.size() == 0) begin
          note_error($sformatf("unexpected result char=%h valid=%b last=%b",
                               got.out_char, got.out_valid, got.out_last));
        end else begin
          want = stripped_q.pop_front();
          if (got.out_char !== want.out_char || got.out_valid !== want.out_valid ||
              got.out_last !== want.out_last)
            note_error($sformatf({"result mismatch: expected char=%h valid=%b last=%b, ",
                                  "got char=%h valid=%b last=%b"},
                                 want.out_char, want.out_valid, want.out_last,
                                 got.out_char, got.out_valid, got.out_last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (chars_bus.valid && chars_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: errors");
    $finish;
  end

  task automatic reg_write(fsr_pkg::reg_index_t idx, logic [fsr_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fsr_pkg::REG_PATTERN_BYTES) pat_bytes = val;
    else pat_len = val[fsr_pkg::LEN_W-1:0];
  endtask

  // wait until every transfer is done and the block has settled
  task automatic drain();
    while (char_q.size() > 0 || chars_bus.valid || stripped_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void put(logic [fsr_pkg::CHAR_W-1:0] c, logic last);
    char_q.push_back('{ch: c, last: last});
  endfunction

  // string of n characters, mostly holding the pattern somewhere, with pattern-like noise
  function automatic void queue_string(int n);
    int                         len;
    int                         spot;
    logic [fsr_pkg::CHAR_W-1:0] c;
    len  = (pat_len > MAXP) ? MAXP : pat_len;
    spot = -1;
    if (len > 0 && len <= n && $urandom_range(0, 3) != 0) spot = $urandom_range(0, n - len);
    for (int i = 0; i < n; i++) begin
      if (spot >= 0 && i >= spot && i < spot + len) c = pat_bytes[8*(i-spot) +: 8];
      else if (len > 0 && $urandom_range(0, 1) == 1)
        c = pat_bytes[8*$urandom_range(0, len - 1) +: 8];
      else c = char_t'($urandom_range(1, 255));
      if (c == 0) c = char_t'($urandom_range(1, 255));
      put(c, i == n - 1);
    end
  endfunction

  initial begin
    int unsigned                   sent;
    int unsigned                   phase_end;
    int                            n;
    logic [fsr_pkg::PATTERN_W-1:0] p;
    chars_bus.valid      = 1'b0;
    chars_bus.char_value = '0;
    chars_bus.is_last    = 1'b0;
    result_bus.ready     = 1'b0;
    pat_bytes  = '0;
    pat_len    = '0;
    win_fill   = 0;
    match_seen = 1'b0;
    quiet      = 1'b0;
    errors     = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // no pattern after reset: straight pass-through, character extremes
    put(8'h01, 1'b0);
    put(8'hFF, 1'b1);
    drain();

    // "ab": removal inside a string, whole string removed, overlap with a false start
    reg_write(fsr_pkg::REG_PATTERN_BYTES, 64'h6261);
    reg_write(fsr_pkg::REG_PATTERN_LENGTH, 64'd2);
    put("x", 1'b0); put("a", 1'b0); put("b", 1'b0); put("y", 1'b1);
    put("a", 1'b0); put("b", 1'b1);
    put("a", 1'b0); put("a", 1'b0); put("b", 1'b1);
    drain();

    // all-ones pattern, length above the maximum taken as eight
    reg_write(fsr_pkg::REG_PATTERN_BYTES, '1);
    reg_write(fsr_pkg::REG_PATTERN_LENGTH, 64'd15);
    for (int i = 0; i < MAXP; i++) put(8'hFF, i == MAXP - 1);
    drain();

    // zero byte in the pattern, then length shrunk and cleared in mid-string
    reg_write(fsr_pkg::REG_PATTERN_BYTES, 64'h0063_6261);
    reg_write(fsr_pkg::REG_PATTERN_LENGTH, 64'd4);
    put("a", 1'b0); put("b", 1'b0); put("c", 1'b0);
    drain();
    reg_write(fsr_pkg::REG_PATTERN_LENGTH, 64'd2);
    put("d", 1'b0);
    drain();
    reg_write(fsr_pkg::REG_PATTERN_LENGTH, 64'd0);
    put("e", 1'b1);
    drain();

    // random phases, each with a fresh pattern
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent + 30 >= RANDOM_ITEMS) quiet = 1'b1;
      for (int b = 0; b < MAXP; b++)
        p[8*b +: 8] = ($urandom_range(0, 1) == 1) ? char_t'(8'h61 + $urandom_range(0, 2))
                                                  : char_t'($urandom_range(0, 255));
      reg_write(fsr_pkg::REG_PATTERN_BYTES, p);
      reg_write(fsr_pkg::REG_PATTERN_LENGTH,
                ($urandom_range(0, 7) == 0) ? word_t'($urandom_range(8, 15))
                                            : word_t'($urandom_range(0, 6)));
      phase_end = sent + 25;
      while (sent < phase_end) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
        queue_string(n);
        sent += n;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fsr_pkg.sv
hdl/fsr_if.sv
hdl/fsr_cfg.sv
hdl/fsr_cell.sv
hdl/first_substring_remover.sv
sim/tb.sv
